// ===== hdl/aabb_pkg.sv =====
// ----------------------------------------------------------------------------
// aabb_pkg: shared types and constants for the bounding box core
// Coordinate format, transform widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package aabb_pkg;

  // coordinate and coefficient formats
  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned COEF_BITS  = 32;

  // rounded product and row sum widths
  localparam int unsigned PROD_BITS  = COEF_BITS + COORD_BITS - FRAC_BITS;
  localparam int unsigned SUM_BITS   = PROD_BITS + 2;

  // configuration port
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 64;
  localparam int unsigned NUM_MAT_REGS  = 6;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_APPLY   = 3'd0,
    REG_M00_M01 = 3'd1,
    REG_M02_TX  = 3'd2,
    REG_M10_M11 = 3'd3,
    REG_M12_TY  = 3'd4,
    REG_M20_M21 = 3'd5,
    REG_M22_TZ  = 3'd6
  } cfg_reg_e;

  // reset matrix is the identity, one entry per matrix register
  localparam logic [NUM_MAT_REGS-1:0][CFG_DATA_BITS-1:0] MAT_RESET = '{
    64'h0001_0000_0000_0000,  // m22, tz
    64'h0000_0000_0000_0000,  // m20, m21
    64'h0000_0000_0000_0000,  // m12, ty
    64'h0000_0000_0001_0000,  // m10, m11
    64'h0000_0000_0000_0000,  // m02, tx
    64'h0001_0000_0000_0000   // m00, m01
  };

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // one matrix row: coefficients for x, y, z, then the translation
  typedef logic [3:0][COEF_BITS-1:0] mat_row_t;
  typedef mat_row_t [2:0] mat_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } point_t;

  typedef struct packed {
    coord_t min_x;
    coord_t max_x;
    coord_t min_y;
    coord_t max_y;
    coord_t min_z;
    coord_t max_z;
  } box_t;

endpackage

// ===== hdl/point_if.sv =====
// ----------------------------------------------------------------------------
// point_if: point request channel
// Valid/ready channel carrying one 3D point and its end-of-run flag.
// ----------------------------------------------------------------------------
interface point_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [aabb_pkg::COORD_BITS-1:0]    point_x;
  logic signed [aabb_pkg::COORD_BITS-1:0]    point_y;
  logic signed [aabb_pkg::COORD_BITS-1:0]    point_z;
  logic                                      last_point;

  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

// ===== hdl/box_if.sv =====
// ----------------------------------------------------------------------------
// box_if: bounding box request channel
// Valid/ready channel carrying the six bounds of a finished run.
// ----------------------------------------------------------------------------
interface box_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [aabb_pkg::COORD_BITS-1:0]    min_x;
  logic signed [aabb_pkg::COORD_BITS-1:0]    max_x;
  logic signed [aabb_pkg::COORD_BITS-1:0]    min_y;
  logic signed [aabb_pkg::COORD_BITS-1:0]    max_y;
  logic signed [aabb_pkg::COORD_BITS-1:0]    min_z;
  logic signed [aabb_pkg::COORD_BITS-1:0]    max_z;

  modport source (output valid, min_x, max_x, min_y, max_y, min_z, max_z, input ready);
  modport sink   (input valid, min_x, max_x, min_y, max_y, min_z, max_z, output ready);
endinterface

// ===== hdl/aabb_from_points_core.sv =====
// ----------------------------------------------------------------------------
// aabb_from_points_core: bounding box of a run of 3D points
// Configuration registers, optional affine transform and running bounds.
// ----------------------------------------------------------------------------
// Throughput: one point per cycle, set by the bounds update; a last point
// stalls while an earlier result waits. A taken last point passes the input,
// product and row-sum registers, then its box loads the result register.
// A waiting result does not block later points until the next last point.
// Reset (async, active low) empties the pipeline, clears the run state and
// sets the transform off with the identity matrix.
module aabb_from_points_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [aabb_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [aabb_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  point_if.sink                                  point_i,
  box_if.source                                  box_o
);

  logic                                                       apply_q;
  logic [aabb_pkg::NUM_MAT_REGS-1:0][aabb_pkg::CFG_DATA_BITS-1:0] mat_reg_q;
  aabb_pkg::mat_t                                             mat;
  logic                                                       xf_valid;
  aabb_pkg::point_t                                           xf_point;
  logic                                                       bnd_take;

  // configuration writes, unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      apply_q   <= 1'b0;
      mat_reg_q <= aabb_pkg::MAT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        aabb_pkg::REG_APPLY:   apply_q      <= cfg_data_i[0];
        aabb_pkg::REG_M00_M01: mat_reg_q[0] <= cfg_data_i;
        aabb_pkg::REG_M02_TX:  mat_reg_q[1] <= cfg_data_i;
        aabb_pkg::REG_M10_M11: mat_reg_q[2] <= cfg_data_i;
        aabb_pkg::REG_M12_TY:  mat_reg_q[3] <= cfg_data_i;
        aabb_pkg::REG_M20_M21: mat_reg_q[4] <= cfg_data_i;
        aabb_pkg::REG_M22_TZ:  mat_reg_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // unpack register pairs into matrix rows
  for (genvar r = 0; r < 3; r++) begin : g_mat
    assign mat[r][0] = mat_reg_q[2*r][63:32];
    assign mat[r][1] = mat_reg_q[2*r][31:0];
    assign mat[r][2] = mat_reg_q[2*r+1][63:32];
    assign mat[r][3] = mat_reg_q[2*r+1][31:0];
  end

  aabb_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .point_i (point_i),
    .apply_i (apply_q),
    .mat_i   (mat),
    .valid_o (xf_valid),
    .point_o (xf_point),
    .take_i  (bnd_take)
  );

  aabb_bnd u_bnd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (xf_valid),
    .point_i (xf_point),
    .take_o  (bnd_take),
    .box_o   (box_o)
  );

endmodule

// ===== hdl/aabb_xform.sv =====
// ----------------------------------------------------------------------------
// aabb_xform: point input register and affine transform pipeline
// Three stages: input register, nine floored products, row sums with
// saturation. Each stage holds one point and moves on when the next frees.
// ----------------------------------------------------------------------------
module aabb_xform (
  input  logic              clk_i,
  input  logic              rst_ni,
  point_if.sink             point_i,
  input  logic              apply_i,
  input  aabb_pkg::mat_t    mat_i,
  output logic              valid_o,
  output aabb_pkg::point_t  point_o,
  input  logic              take_i
);

  localparam int unsigned PFULL = aabb_pkg::COEF_BITS + aabb_pkg::COORD_BITS;
  localparam int unsigned PB    = aabb_pkg::PROD_BITS;
  localparam int unsigned SB    = aabb_pkg::SUM_BITS;
  localparam int unsigned CB    = aabb_pkg::COORD_BITS;

  logic              v1_q, v2_q, v3_q;
  logic              rdy1, rdy2, rdy3;
  aabb_pkg::point_t  p1_q, p2_q, p3_q, p3_d;

  logic signed [CB-1:0]    pc [3];
  logic signed [PFULL-1:0] prod_full [3][3];
  logic signed [PB-1:0]    prod_d [3][3];
  logic signed [PB-1:0]    prod_q [3][3];
  logic signed [SB-1:0]    sum [3];
  logic signed [CB-1:0]    sat [3];

  // stage hand-over, a stage frees when empty or moving on
  assign rdy3          = !v3_q || take_i;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign point_i.ready = rdy1;

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= point_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // coordinates of the stage one point as an array
  assign pc[0] = p1_q.x;
  assign pc[1] = p1_q.y;
  assign pc[2] = p1_q.z;

  // nine products, floored by the fraction shift
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      assign prod_full[r][c] = $signed(mat_i[r][c]) * pc[c];
      assign prod_d[r][c]    = PB'(prod_full[r][c] >>> aabb_pkg::FRAC_BITS);
    end
    // row sum with translation, then clamp to the coordinate range
    assign sum[r] = SB'($signed(mat_i[r][3])) + SB'(prod_q[r][0])
                  + SB'(prod_q[r][1]) + SB'(prod_q[r][2]);
    always_comb begin
      if ((&sum[r][SB-1:CB-1]) || !(|sum[r][SB-1:CB-1])) begin
        sat[r] = sum[r][CB-1:0];
      end else if (sum[r][SB-1]) begin
        sat[r] = {1'b1, {(CB-1){1'b0}}};
      end else begin
        sat[r] = {1'b0, {(CB-1){1'b1}}};
      end
    end
  end

  // transformed or untouched point
  always_comb begin
    p3_d      = p2_q;
    if (apply_i) begin
      p3_d.x = sat[0];
      p3_d.y = sat[1];
      p3_d.z = sat[2];
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (point_i.valid && rdy1) begin
      p1_q.x    <= point_i.point_x;
      p1_q.y    <= point_i.point_y;
      p1_q.z    <= point_i.point_z;
      p1_q.last <= point_i.last_point;
    end
    if (v1_q && rdy2) begin
      p2_q <= p1_q;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= prod_d[r][c];
        end
      end
    end
    if (v2_q && rdy3) begin
      p3_q <= p3_d;
    end
  end

  assign valid_o = v3_q;
  assign point_o = p3_q;

endmodule

// ===== hdl/aabb_bnd.sv =====
// ----------------------------------------------------------------------------
// aabb_bnd: running bounds and result register
// Seeds the six bounds on the first point of a run, widens them on later
// points and loads the result register on the last point.
// ----------------------------------------------------------------------------
module aabb_bnd (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  aabb_pkg::point_t  point_i,
  output logic              take_o,
  box_if.source             box_o
);

  logic              started_q;
  logic              out_valid_q;
  logic              out_free;
  aabb_pkg::box_t    bnd_q, bnd_d;
  aabb_pkg::box_t    box_q;

  // a last point needs the result register, others never wait
  assign out_free = !out_valid_q || box_o.ready;
  assign take_o   = valid_i && (!point_i.last || out_free);

  // seed or widen each axis
  always_comb begin
    if (!started_q) begin
      bnd_d.min_x = point_i.x;
      bnd_d.max_x = point_i.x;
      bnd_d.min_y = point_i.y;
      bnd_d.max_y = point_i.y;
      bnd_d.min_z = point_i.z;
      bnd_d.max_z = point_i.z;
    end else begin
      bnd_d.min_x = (point_i.x < bnd_q.min_x) ? point_i.x : bnd_q.min_x;
      bnd_d.max_x = (bnd_q.max_x < point_i.x) ? point_i.x : bnd_q.max_x;
      bnd_d.min_y = (point_i.y < bnd_q.min_y) ? point_i.y : bnd_q.min_y;
      bnd_d.max_y = (bnd_q.max_y < point_i.y) ? point_i.y : bnd_q.max_y;
      bnd_d.min_z = (point_i.z < bnd_q.min_z) ? point_i.z : bnd_q.min_z;
      bnd_d.max_z = (bnd_q.max_z < point_i.z) ? point_i.z : bnd_q.max_z;
    end
  end

  // run state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        started_q <= !point_i.last;
      end
      if (take_o && point_i.last) begin
        out_valid_q <= 1'b1;
      end else if (box_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // bounds and result payload
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      bnd_q <= bnd_d;
    end
    if (take_o && point_i.last) begin
      box_q <= bnd_d;
    end
  end

  assign box_o.valid = out_valid_q;
  assign box_o.min_x = box_q.min_x;
  assign box_o.max_x = box_q.max_x;
  assign box_o.min_y = box_q.min_y;
  assign box_o.max_y = box_q.max_y;
  assign box_o.min_z = box_q.min_z;
  assign box_o.max_z = box_q.max_z;

  // a finished run always shows up on the result register
  a_last_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && point_i.last |=> out_valid_q)
    else $error("last point did not load the result register");

  // a last point ends the run, any other point keeps it going
  a_run_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |=> (started_q == !$past(point_i.last)))
    else $error("run state not updated after a point");

  // bounds are ordered on every axis
  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (box_q.min_x <= box_q.max_x) && (box_q.min_y <= box_q.max_y)
                    && (box_q.min_z <= box_q.max_z))
    else $error("result bounds out of order");

  // a waiting result must not be overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !box_o.ready |-> !(take_o && point_i.last))
    else $error("result register overwritten while waiting");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for aabb_from_points_core
// Streams runs of points through the core and predicts each bounding box
// with a local model of the transform and the running min/max. A directed
// script covers extremes, saturation, rounding and register corner cases;
// randomised phases follow, each under a fresh register setting.
// ----------------------------------------------------------------------------
module tb;
  import aabb_pkg::*;

  localparam int          DRAIN_CYCLES = 8;
  localparam int          TIMEOUT_NS   = 5_000_000;
  localparam int          PHASES       = 8;
  localparam int          PHASE_POINTS = 94;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;

  localparam coord_t            COORD_MAX = 32'sh7fff_ffff;
  localparam coord_t            COORD_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] SAT_HI   = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] SAT_LO   = 64'shffff_ffff_8000_0000;
  localparam logic [31:0]        Q_ONE    = 32'h0001_0000;

  // one line of the directed script: a register write or a point
  typedef struct {
    bit                       is_write;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] data;
    point_t                   pt;
    bit                       known;
    box_t                     box;
  } script_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  point_if pnt ();
  box_if   box ();

  aabb_from_points_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .point_i    (pnt),
    .box_o      (box)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: registers and running bounds
  bit          xform_on;
  logic [63:0] mat_reg [6];
  coord_t      lo_bound [3];
  coord_t      hi_bound [3];
  bit          run_open;

  box_t          pending_boxes [$];
  script_row_t   script [$];
  int            err_count  = 0;
  int            burst_left = 0;

  cfg_reg_e mat_list [6] = '{REG_M00_M01, REG_M02_TX, REG_M10_M11,
                             REG_M12_TY, REG_M20_M21, REG_M22_TZ};

  // one output axis of the affine transform, floor rounding, saturated sum
  function automatic coord_t transform_axis(input int r, input coord_t px,
                                            input coord_t py, input coord_t pz);
    logic signed [31:0] cx, cy, cz, tr;
    logic signed [63:0] prod, acc;
    cx   = mat_reg[2*r][63:32];
    cy   = mat_reg[2*r][31:0];
    cz   = mat_reg[2*r+1][63:32];
    tr   = mat_reg[2*r+1][31:0];
    acc  = tr;
    prod = cx * px;
    acc  = acc + (prod >>> FRAC_BITS);
    prod = cy * py;
    acc  = acc + (prod >>> FRAC_BITS);
    prod = cz * pz;
    acc  = acc + (prod >>> FRAC_BITS);
    if (acc > SAT_HI) return COORD_MAX;
    if (acc < SAT_LO) return COORD_MIN;
    return acc[31:0];
  endfunction

  // fold one point into the running box; returns 1 when a box is due
  function automatic bit accumulate_bounds(input point_t p, output box_t b);
    coord_t v [3];
    coord_t q;
    v = '{p.x, p.y, p.z};
    for (int a = 0; a < 3; a++) begin
      q = xform_on ? transform_axis(a, v[0], v[1], v[2]) : v[a];
      if (!run_open) begin
        lo_bound[a] = q;
        hi_bound[a] = q;
      end else begin
        if (q < lo_bound[a]) lo_bound[a] = q;
        if (q > hi_bound[a]) hi_bound[a] = q;
      end
    end
    b = '{lo_bound[0], hi_bound[0], lo_bound[1], hi_bound[1],
          lo_bound[2], hi_bound[2]};
    run_open = !p.last;
    return p.last;
  endfunction

  function automatic box_t mk_box(input coord_t a, input coord_t b, input coord_t c,
                                  input coord_t d, input coord_t e, input coord_t f);
    return '{a, b, c, d, e, f};
  endfunction

  function automatic void add_write(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] data);
    script_row_t r;
    r          = '{default: '0};
    r.is_write = 1'b1;
    r.idx      = idx;
    r.data     = data;
    script.push_back(r);
  endfunction

  function automatic void add_point(input coord_t x, input coord_t y, input coord_t z,
                                    input bit last);
    script_row_t r;
    r    = '{default: '0};
    r.pt = '{x, y, z, last};
    script.push_back(r);
  endfunction

  // last point of a run whose box is written out by hand
  function automatic void add_known(input coord_t x, input coord_t y, input coord_t z,
                                    input box_t b);
    script_row_t r;
    r       = '{default: '0};
    r.pt    = '{x, y, z, 1'b1};
    r.known = 1'b1;
    r.box   = b;
    script.push_back(r);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 6))
      0, 1:    return $urandom_range(0, 32'h3ffff) - 32'h2_0000;
      2:       return COORD_MAX;
      3:       return COORD_MIN;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 6))
      0:       return 32'h0;
      1:       return Q_ONE;
      2:       return -Q_ONE;
      3, 4:    return $urandom_range(0, 32'h3ffff) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk_i);
      pnt.valid <= 1'b0;
    end
  endtask

  // drop valid, wait for every box, then let the pipeline empty
  task automatic settle_block();
    @(negedge clk_i);
    pnt.valid <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    if (idx == REG_APPLY) xform_on = data[0];
    else if (idx <= REG_M22_TZ) mat_reg[idx - 1] = data;
  endtask

  // send one point request in bursts, predict once it is taken
  task automatic issue_point(input point_t p, input bit known, input box_t kbox);
    box_t b;
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk_i);
    pnt.valid      <= 1'b1;
    pnt.point_x    <= p.x;
    pnt.point_y    <= p.y;
    pnt.point_z    <= p.z;
    pnt.last_point <= p.last;
    do @(posedge clk_i); while (pnt.ready !== 1'b1);
    if (accumulate_bounds(p, b)) pending_boxes.push_back(known ? kbox : b);
  endtask

  // receiver stalls: the mode is chosen by bits 8:7 of a free-running counter
  logic [15:0] rx_cycle = '0;
  int unsigned rx_hold  = 0;

  always @(negedge clk_i) begin
    rx_cycle <= rx_cycle + 1'b1;
    if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      box.ready <= 1'b0;
    end else begin
      case (rx_cycle[8:7])
        2'd0: box.ready <= 1'b1;
        2'd1: box.ready <= ($urandom_range(0, 1) == 1);
        2'd2: box.ready <= (rx_cycle[1:0] != 2'd0);
        default: begin
          box.ready <= 1'b1;
          if ($urandom_range(0, 15) == 0) rx_hold <= $urandom_range(1, 20);
        end
      endcase
    end
  end

  task automatic check_field(input string name, input coord_t exp, input coord_t act);
    if (exp !== act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      err_count++;
    end
  endtask

  // compare each taken box request with the oldest prediction
  always @(posedge clk_i) begin
    box_t e;
    if (rst_ni === 1'b1 && box.valid === 1'b1 && box.ready === 1'b1) begin
      if (pending_boxes.size() == 0) begin
        $error("box: none expected, got min_x %0d max_x %0d", box.min_x, box.max_x);
        err_count++;
      end else begin
        e = pending_boxes.pop_front();
        check_field("min_x", e.min_x, box.min_x);
        check_field("max_x", e.max_x, box.max_x);
        check_field("min_y", e.min_y, box.min_y);
        check_field("max_y", e.max_y, box.max_y);
        check_field("min_z", e.min_z, box.min_z);
        check_field("max_z", e.max_z, box.max_z);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    point_t p;
    bit     drained;
    int     n, len;
    logic [CFG_DATA_BITS-1:0] d;

    // known levels on every input, predictor at its reset state
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_APPLY;
    cfg_data       = '0;
    pnt.valid      = 1'b0;
    pnt.point_x    = '0;
    pnt.point_y    = '0;
    pnt.point_z    = '0;
    pnt.last_point = 1'b0;
    box.ready      = 1'b0;
    xform_on       = 1'b0;
    mat_reg        = '{64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000,
                       64'h0, 64'h0, 64'h0001_0000_0000_0000};
    lo_bound       = '{default: '0};
    hi_bound       = '{default: '0};
    run_open       = 1'b0;

    // transform off: single-point runs at the extremes, then a mixed run
    add_known(0, 0, 0, mk_box(0, 0, 0, 0, 0, 0));
    add_known(COORD_MAX, COORD_MAX, COORD_MAX, mk_box(COORD_MAX, COORD_MAX, COORD_MAX,
                                                      COORD_MAX, COORD_MAX, COORD_MAX));
    add_known(COORD_MIN, COORD_MIN, COORD_MIN, mk_box(COORD_MIN, COORD_MIN, COORD_MIN,
                                                      COORD_MIN, COORD_MIN, COORD_MIN));
    add_point(COORD_MAX, COORD_MIN, 0, 1'b0);
    add_point(COORD_MIN, COORD_MAX, -1, 1'b0);
    add_known(1, -1, 1, mk_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, -1, 1));
    // wide value with low bit clear keeps the transform off
    add_write(REG_APPLY, 64'hffff_ffff_ffff_fffe);
    add_known(5, 6, 7, mk_box(5, 5, 6, 6, 7, 7));
    // transform on with the reset identity
    add_write(REG_APPLY, 64'hffff_ffff_ffff_ffff);
    add_known(COORD_MIN, COORD_MAX, 123456, mk_box(COORD_MIN, COORD_MIN, COORD_MAX,
                                                   COORD_MAX, 123456, 123456));
    // write to the spare index must be ignored
    add_write(REG_SPARE, 64'hffff_ffff_ffff_ffff);
    add_known(32'h1_0000, 32'h2_0000, 32'h3_0000, mk_box(32'h1_0000, 32'h1_0000,
                                                         32'h2_0000, 32'h2_0000,
                                                         32'h3_0000, 32'h3_0000));
    // largest coefficients: row x saturates both ways
    add_write(REG_M00_M01, 64'h7fff_ffff_7fff_ffff);
    add_write(REG_M02_TX,  64'h7fff_ffff_7fff_ffff);
    add_known(COORD_MAX, COORD_MAX, COORD_MAX, mk_box(COORD_MAX, COORD_MAX, COORD_MAX,
                                                      COORD_MAX, COORD_MAX, COORD_MAX));
    add_known(COORD_MIN, COORD_MIN, COORD_MIN, mk_box(COORD_MIN, COORD_MIN, COORD_MIN,
                                                      COORD_MIN, COORD_MIN, COORD_MIN));
    // all-ones and most negative coefficients, floor rounding of tiny products
    add_write(REG_M10_M11, 64'hffff_ffff_ffff_ffff);
    add_write(REG_M12_TY,  64'hffff_ffff_ffff_ffff);
    add_write(REG_M20_M21, 64'h8000_0000_8000_0000);
    add_write(REG_M22_TZ,  64'h8000_0000_8000_0000);
    add_point(-1, -1, -1, 1'b0);
    add_point(1, 1, 1, 1'b0);
    add_point(COORD_MAX, COORD_MIN, 32'h1234_5678, 1'b0);
    add_point(0, 0, 0, 1'b1);
    // half coefficient: negative odd values round down
    add_write(REG_M00_M01, 64'h0000_8000_0000_0000);
    add_write(REG_M02_TX,  64'h0);
    add_point(-1, 0, 0, 1'b1);
    add_point(1, 2, 3, 1'b1);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // walk the directed script
    drained = 1'b1;
    foreach (script[i]) begin
      if (script[i].is_write) begin
        if (!drained) settle_block();
        drained = 1'b1;
        write_reg(script[i].idx, script[i].data);
      end else begin
        drained = 1'b0;
        issue_point(script[i].pt, script[i].known, script[i].box);
      end
    end

    // random phases, each with a fresh register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      settle_block();
      d    = {$urandom, $urandom};
      d[0] = (ph % 4 != 0);
      write_reg(REG_APPLY, d);
      foreach (mat_list[k]) begin
        if (ph == 0 || $urandom_range(0, 3) != 0) write_reg(mat_list[k], {rand_coef(), rand_coef()});
      end
      if ($urandom_range(0, 1) == 1) write_reg(REG_SPARE, {$urandom, $urandom});
      n = 0;
      while (n < PHASE_POINTS) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          p = '{rand_coord(), rand_coord(), rand_coord(), k == len - 1};
          issue_point(p, 1'b0, '0);
        end
        n += len;
      end
    end

    settle_block();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
